// File: rtl/kta_pkg.sv
package kta_pkg;

    // input item kinds
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    // track codes
    localparam logic [2:0] TRK_COLOR  = 3'd0;
    localparam logic [2:0] TRK_ALPHA  = 3'd1;
    localparam logic [2:0] TRK_ANGLE  = 3'd2;
    localparam logic [2:0] TRK_SCALE  = 3'd3;
    localparam logic [2:0] TRK_OFFSET = 3'd4;
    localparam int unsigned NUM_TRACKS = 5;

    // configuration register indexes
    localparam logic CFG_CYCLE = 1'b0;
    localparam logic CFG_PLAY  = 1'b1;

    // field widths
    localparam int unsigned TIME_W  = 24;
    localparam int unsigned VAL_W   = 48;
    localparam int unsigned ENTRY_W = 2 * TIME_W + VAL_W;

    // blend datapath: a*(span-d) + b*d needs 56 bits plus sign
    localparam int unsigned ACC_W = 58;
    localparam int unsigned MAG_W = 57;
    localparam int unsigned REM_W = TIME_W + 1;

endpackage

// File: rtl/kta_ram.sv
module kta_ram #(
    parameter int unsigned WIDTH = 96,
    parameter int unsigned DEPTH = 80
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/kta_mod.sv
module kta_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [31:0]                 i_dividend,
    input  logic [kta_pkg::TIME_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [kta_pkg::TIME_W-1:0]  o_rem
);
    import kta_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [4:0]       r_cnt;
    logic [31:0]      r_num;
    logic [REM_W-1:0] r_rem;
    logic [TIME_W-1:0] r_div;

    logic [REM_W-1:0] w_t;
    logic             w_ge;
    logic [REM_W-1:0] w_sub;

    // one quotient bit a cycle, restoring
    assign w_t   = {r_rem[TIME_W-1:0], r_num[31]};
    assign w_ge  = w_t >= {1'b0, r_div};
    assign w_sub = w_t - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_start) begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                    r_num  <= i_dividend;
                    r_div  <= i_divisor;
                    r_rem  <= '0;
                end
            end else begin
                r_rem <= w_ge ? w_sub : w_t;
                r_num <= {r_num[30:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[TIME_W-1:0];

endmodule

// File: rtl/kta_blend.sv
module kta_blend (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [31:0]          i_a,
    input  logic signed [31:0]          i_b,
    input  logic [kta_pkg::TIME_W-1:0]  i_d,
    input  logic [kta_pkg::TIME_W-1:0]  i_span,
    output logic                        o_done,
    output logic signed [31:0]          o_res
);
    import kta_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_NORM,
        B_DIV
    } t_bstate;

    t_bstate                  r_state;
    logic                     r_done;
    logic [5:0]               r_cnt;
    logic signed [ACC_W-1:0]  r_acc;
    logic [TIME_W-1:0]        r_m1;
    logic [TIME_W-1:0]        r_m2;
    logic signed [31:0]       r_a;
    logic signed [31:0]       r_b;
    logic [TIME_W-1:0]        r_span;
    logic [MAG_W-1:0]         r_mag;
    logic [REM_W-1:0]         r_rem;
    logic [31:0]              r_q;
    logic                     r_neg;
    logic signed [31:0]       r_res;

    logic signed [ACC_W-1:0]  w_pa;
    logic signed [ACC_W-1:0]  w_pb;
    logic signed [ACC_W-1:0]  w_step;
    logic signed [ACC_W-1:0]  w_nacc;
    logic [REM_W-1:0]         w_t;
    logic                     w_ge;
    logic [REM_W-1:0]         w_sub;
    logic [31:0]              w_q;

    // msb-first shift-add over the two multiplier words at once
    assign w_pa   = r_m1[TIME_W-1] ? {{(ACC_W-32){r_a[31]}}, r_a} : '0;
    assign w_pb   = r_m2[TIME_W-1] ? {{(ACC_W-32){r_b[31]}}, r_b} : '0;
    assign w_step = (r_acc <<< 1) + w_pa + w_pb;
    assign w_nacc = -r_acc;

    // restoring division of the magnitude by span
    assign w_t   = {r_rem[TIME_W-1:0], r_mag[MAG_W-1]};
    assign w_ge  = w_t >= {1'b0, r_span};
    assign w_sub = w_t - {1'b0, r_span};
    assign w_q   = {r_q[30:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                B_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_a;
                        r_b     <= i_b;
                        r_m1    <= i_span - i_d;
                        r_m2    <= i_d;
                        r_span  <= i_span;
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= B_MUL;
                    end
                end
                B_MUL: begin
                    r_acc <= w_step;
                    r_m1  <= {r_m1[TIME_W-2:0], 1'b0};
                    r_m2  <= {r_m2[TIME_W-2:0], 1'b0};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(TIME_W - 1)) begin
                        r_state <= B_NORM;
                    end
                end
                B_NORM: begin
                    r_neg   <= r_acc[ACC_W-1];
                    r_mag   <= r_acc[ACC_W-1] ? w_nacc[MAG_W-1:0] : r_acc[MAG_W-1:0];
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    r_rem <= w_ge ? w_sub : w_t;
                    r_mag <= {r_mag[MAG_W-2:0], 1'b0};
                    r_q   <= w_q;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(MAG_W - 1)) begin
                        r_res   <= r_neg ? -$signed(w_q) : $signed(w_q);
                        r_done  <= 1'b1;
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// File: rtl/keyframe_track_animator.sv
// channel   direction  handshake            payload
// input     in         i_valid / o_stall    kind, track, key_start, key_span, key_value(_y), tick_ms
// output    out        o_valid / i_stall    color_argb, angle_deg, scale_factor, offset_x/y, plays_left
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// clear and append items are handled while idle and do not stall the input; a tick
// runs the bit-serial remainder, reads the key memory key by key during each track
// search, and runs up to eight blends in the serial multiply/divide unit (three
// colour channels, alpha, angle, scale, offset x and y)
// synchronous active-low reset; key memory is not cleared, key counts are cleared
// the input is stalled for the whole of a running tick (ticks while plays is zero are dropped);
// a result waits in the output register while the next item is taken
module keyframe_track_animator #(
    parameter int unsigned MAX_KEYS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_kind,
    input  logic [2:0]          i_track,
    input  logic [23:0]         i_key_start,
    input  logic [23:0]         i_key_span,
    input  logic signed [31:0]  i_key_value,
    input  logic signed [15:0]  i_key_value_y,
    input  logic [15:0]         i_tick_ms,
    // output channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [31:0]         o_color_argb,
    output logic signed [23:0]  o_angle_deg,
    output logic [15:0]         o_scale_factor,
    output logic signed [15:0]  o_offset_x,
    output logic signed [15:0]  o_offset_y,
    output logic signed [8:0]   o_plays_left,
    // configuration
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [23:0]         i_cfg_data
);
    import kta_pkg::*;

    localparam int unsigned DEPTH = NUM_TRACKS * MAX_KEYS;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(MAX_KEYS + 1);
    localparam int unsigned IW    = $clog2(MAX_KEYS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_MOD,
        S_TRK,
        S_RDW,
        S_SRCH,
        S_LAST,
        S_GOTB,
        S_BLEND,
        S_BWAIT,
        S_NEXT,
        S_PUSH
    } t_state;

    // control state
    t_state             r_state;
    t_state             r_ret;
    logic [23:0]        r_cycle;
    logic signed [8:0]  r_plays;
    logic [31:0]        r_elapsed;
    logic [CW-1:0]      r_cnt [NUM_TRACKS];
    logic               r_out_valid;
    logic [2:0]         r_trk;
    logic [IW-1:0]      r_idx;
    logic [1:0]         r_sub;
    logic               r_gt;
    logic               r_fin;

    // working payload
    logic [23:0]        r_now;
    logic [23:0]        r_d;
    logic [23:0]        r_span;
    logic [VAL_W-1:0]   r_a;
    logic [VAL_W-1:0]   r_b;
    logic [23:0]        r_color;
    logic [7:0]         r_alpha;
    logic [23:0]        r_ang;
    logic [15:0]        r_scl;
    logic [15:0]        r_ox;
    logic [15:0]        r_oy;

    // output register
    logic [31:0]        r_o_color;
    logic [23:0]        r_o_ang;
    logic [15:0]        r_o_scl;
    logic [15:0]        r_o_ox;
    logic [15:0]        r_o_oy;
    logic [8:0]         r_o_plays;

    logic               w_accept;
    logic               w_push;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [AW-1:0]      w_raddr;
    logic [ENTRY_W-1:0] w_rdata;
    logic [VAL_W-1:0]   w_rval;
    logic [23:0]        w_rstart;
    logic [23:0]        w_rspan;
    logic [24:0]        w_rend;
    logic               w_hit;
    logic [CW-1:0]      w_n;
    logic [CW-1:0]      w_idx1;
    logic               w_more;
    logic [IW-1:0]      w_last;
    logic [32:0]        w_sum;
    logic [23:0]        w_cyc;
    logic               w_gt;
    logic               w_mod_start;
    logic               w_mod_done;
    logic [23:0]        w_mod_rem;
    logic               w_bl_start;
    logic               w_bl_done;
    logic signed [31:0] w_bl_res;
    logic signed [31:0] w_bl_a;
    logic signed [31:0] w_bl_b;
    logic [1:0]         w_sub_last;

    // pick the part of a stored value that one blend works on
    function automatic logic signed [31:0] f_part(
        input logic [VAL_W-1:0] v,
        input logic [2:0]       trk,
        input logic [1:0]       sub
    );
        logic signed [31:0] res;
        res = v[31:0];
        if (trk == TRK_COLOR) begin
            case (sub)
                2'd0:    res = {24'd0, v[7:0]};
                2'd1:    res = {24'd0, v[15:8]};
                default: res = {24'd0, v[23:16]};
            endcase
        end else if (trk == TRK_OFFSET && sub == 2'd1) begin
            res = {{16{v[47]}}, v[47:32]};
        end
        return res;
    endfunction

    function automatic logic [23:0] f_clamp24(input logic signed [31:0] v);
        logic [23:0] res;
        if (v > 32'sd8388607) begin
            res = 24'h7fffff;
        end else if (v < -32'sd8388608) begin
            res = 24'h800000;
        end else begin
            res = v[23:0];
        end
        return res;
    endfunction

    function automatic logic [15:0] f_clamp_u16(input logic signed [31:0] v);
        logic [15:0] res;
        if (v < 32'sd0) begin
            res = 16'h0000;
        end else if (v > 32'sd65535) begin
            res = 16'hffff;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    function automatic logic [15:0] f_clamp_s16(input logic signed [31:0] v);
        logic [15:0] res;
        if (v > 32'sd32767) begin
            res = 16'h7fff;
        end else if (v < -32'sd32768) begin
            res = 16'h8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    assign w_accept = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);

    // result moves into the output register once it is free or being taken
    assign w_push = (r_state == S_PUSH) && (!r_out_valid || !i_stall);

    // append write into the key memory
    assign w_we = w_accept && (i_kind == KIND_APPEND) && (i_track < 3'(NUM_TRACKS))
                  && (r_cnt[i_track] < CW'(MAX_KEYS));
    assign w_waddr = AW'(i_track) * AW'(MAX_KEYS) + AW'(r_cnt[i_track]);
    assign w_raddr = AW'(r_trk) * AW'(MAX_KEYS) + AW'(r_idx);

    kta_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_keys (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({i_key_start, i_key_span, i_key_value_y, i_key_value}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // entry layout: start, span, value y, value x
    assign w_rval   = w_rdata[VAL_W-1:0];
    assign w_rspan  = w_rdata[VAL_W+23:VAL_W];
    assign w_rstart = w_rdata[ENTRY_W-1:ENTRY_W-24];
    assign w_rend   = {1'b0, w_rstart} + {1'b0, w_rspan};
    assign w_hit    = (w_rstart < r_now) && ({1'b0, r_now} <= w_rend);

    assign w_n    = r_cnt[r_trk];
    assign w_idx1 = CW'(r_idx) + CW'(1);
    assign w_more = w_idx1 < w_n;
    assign w_last = IW'(w_n - CW'(1));

    // elapsed time saturates, zero cycle length acts as one
    assign w_sum = {1'b0, r_elapsed} + {17'd0, i_tick_ms};
    assign w_cyc = (r_cycle == 24'd0) ? 24'd1 : r_cycle;
    assign w_gt  = r_elapsed > {8'd0, w_cyc};

    assign w_mod_start = (r_state == S_PREP);

    kta_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (r_elapsed),
        .i_divisor  (w_cyc),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    assign w_bl_start = (r_state == S_BLEND);
    assign w_bl_a     = f_part(r_a, r_trk, r_sub);
    assign w_bl_b     = f_part(r_b, r_trk, r_sub);

    kta_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_bl_start),
        .i_a     (w_bl_a),
        .i_b     (w_bl_b),
        .i_d     (r_d),
        .i_span  (r_span),
        .o_done  (w_bl_done),
        .o_res   (w_bl_res)
    );

    // colour blends three channels, offset two parts, the rest one
    always_comb begin
        case (r_trk)
            TRK_COLOR:  w_sub_last = 2'd2;
            TRK_OFFSET: w_sub_last = 2'd1;
            default:    w_sub_last = 2'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_cycle     <= 24'd3000;
            r_plays     <= -9'sd1;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
            r_trk       <= TRK_COLOR;
            r_idx       <= '0;
            r_sub       <= '0;
            r_gt        <= 1'b0;
            r_fin       <= 1'b0;
            for (int t = 0; t < NUM_TRACKS; t++) begin
                r_cnt[t] <= '0;
            end
        end else begin
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            // configuration is to be written only while idle; the block itself does not enforce this
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CYCLE: r_cycle <= i_cfg_data;
                    CFG_PLAY:  r_plays <= i_cfg_data[8:0];
                    default:   r_cycle <= r_cycle;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_kind)
                            KIND_CLEAR: begin
                                for (int t = 0; t < NUM_TRACKS; t++) begin
                                    r_cnt[t] <= '0;
                                end
                            end
                            KIND_APPEND: begin
                                if (w_we) begin
                                    r_cnt[i_track] <= r_cnt[i_track] + CW'(1);
                                end
                            end
                            KIND_TICK: begin
                                if (r_plays != 9'sd0) begin
                                    r_elapsed <= w_sum[32] ? 32'hffffffff : w_sum[31:0];
                                    r_state   <= S_PREP;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_PREP: begin
                    r_gt <= w_gt;
                    if (w_gt && !r_plays[8] && r_plays != 9'sd0) begin
                        r_plays <= r_plays - 9'sd1;
                    end
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (w_mod_done) begin
                        r_now   <= w_mod_rem;
                        r_fin   <= r_gt && (r_plays != -9'sd1);
                        r_trk   <= TRK_COLOR;
                        r_state <= S_TRK;
                    end
                end
                S_TRK: begin
                    if (w_n == '0) begin
                        // empty track defaults
                        case (r_trk)
                            TRK_COLOR: r_color <= 24'hffffff;
                            TRK_ALPHA: r_alpha <= 8'hff;
                            TRK_ANGLE: r_ang   <= 24'd0;
                            TRK_SCALE: r_scl   <= 16'd256;
                            default: begin
                                r_ox <= 16'd0;
                                r_oy <= 16'd0;
                            end
                        endcase
                        r_state <= S_NEXT;
                    end else if (r_fin) begin
                        if (r_trk == TRK_ANGLE) begin
                            r_ang   <= 24'd0;
                            r_state <= S_NEXT;
                        end else if (r_trk == TRK_OFFSET) begin
                            r_ox    <= 16'd0;
                            r_oy    <= 16'd0;
                            r_state <= S_NEXT;
                        end else begin
                            r_idx   <= w_last;
                            r_ret   <= S_LAST;
                            r_state <= S_RDW;
                        end
                    end else begin
                        r_idx   <= '0;
                        r_ret   <= S_SRCH;
                        r_state <= S_RDW;
                    end
                end
                S_RDW: begin
                    // memory takes the address this cycle
                    r_state <= r_ret;
                end
                S_SRCH: begin
                    if (w_hit) begin
                        r_a    <= w_rval;
                        r_d    <= r_now - w_rstart;
                        r_span <= w_rspan;
                        if (r_trk == TRK_COLOR && !w_more) begin
                            // last colour key holds its own value
                            r_color <= w_rval[23:0];
                            r_state <= S_NEXT;
                        end else begin
                            r_idx   <= w_more ? IW'(w_idx1) : '0;
                            r_ret   <= S_GOTB;
                            r_state <= S_RDW;
                        end
                    end else if (w_more) begin
                        r_idx   <= IW'(w_idx1);
                        r_ret   <= S_SRCH;
                        r_state <= S_RDW;
                    end else begin
                        r_idx   <= w_last;
                        r_ret   <= S_LAST;
                        r_state <= S_RDW;
                    end
                end
                S_LAST: begin
                    case (r_trk)
                        TRK_COLOR: r_color <= w_rval[23:0];
                        TRK_ALPHA: r_alpha <= w_rval[7:0];
                        TRK_ANGLE: r_ang   <= f_clamp24(f_part(w_rval, r_trk, 2'd0));
                        TRK_SCALE: r_scl   <= f_clamp_u16(f_part(w_rval, r_trk, 2'd0));
                        default: begin
                            r_ox <= f_clamp_s16(f_part(w_rval, r_trk, 2'd0));
                            r_oy <= f_clamp_s16(f_part(w_rval, r_trk, 2'd1));
                        end
                    endcase
                    r_state <= S_NEXT;
                end
                S_GOTB: begin
                    r_b     <= w_rval;
                    r_sub   <= '0;
                    r_state <= S_BLEND;
                end
                S_BLEND: begin
                    r_state <= S_BWAIT;
                end
                S_BWAIT: begin
                    if (w_bl_done) begin
                        case (r_trk)
                            TRK_COLOR: begin
                                case (r_sub)
                                    2'd0:    r_color[7:0]   <= w_bl_res[7:0];
                                    2'd1:    r_color[15:8]  <= w_bl_res[7:0];
                                    default: r_color[23:16] <= w_bl_res[7:0];
                                endcase
                            end
                            TRK_ALPHA: r_alpha <= w_bl_res[7:0];
                            TRK_ANGLE: r_ang   <= f_clamp24(w_bl_res);
                            TRK_SCALE: r_scl   <= f_clamp_u16(w_bl_res);
                            default: begin
                                if (r_sub == 2'd0) begin
                                    r_ox <= f_clamp_s16(w_bl_res);
                                end else begin
                                    r_oy <= f_clamp_s16(w_bl_res);
                                end
                            end
                        endcase
                        if (r_sub == w_sub_last) begin
                            r_state <= S_NEXT;
                        end else begin
                            r_sub   <= r_sub + 2'd1;
                            r_state <= S_BLEND;
                        end
                    end
                end
                S_NEXT: begin
                    if (r_trk == TRK_OFFSET) begin
                        r_state <= S_PUSH;
                    end else begin
                        r_trk   <= r_trk + 3'd1;
                        r_state <= S_TRK;
                    end
                end
                S_PUSH: begin
                    // wait for the output register to free up
                    if (w_push) begin
                        r_o_color   <= {r_alpha, r_color[7:0], r_color[15:8], r_color[23:16]};
                        r_o_ang     <= r_ang;
                        r_o_scl     <= r_scl;
                        r_o_ox      <= r_ox;
                        r_o_oy      <= r_oy;
                        r_o_plays   <= r_plays;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_color_argb   = r_o_color;
    assign o_angle_deg    = r_o_ang;
    assign o_scale_factor = r_o_scl;
    assign o_offset_x     = r_o_ox;
    assign o_offset_y     = r_o_oy;
    assign o_plays_left   = r_o_plays;

endmodule

// File: bench/kta_checker.sv
module kta_checker #(
    parameter int unsigned MAX_KEYS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_kind,
    input  logic [2:0]         i_track,
    input  logic [23:0]        i_key_start,
    input  logic [23:0]        i_key_span,
    input  logic signed [31:0] i_key_value,
    input  logic signed [15:0] i_key_value_y,
    input  logic [15:0]        i_tick_ms,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [31:0]        i_color_argb,
    input  logic signed [23:0] i_angle_deg,
    input  logic [15:0]        i_scale_factor,
    input  logic signed [15:0] i_offset_x,
    input  logic signed [15:0] i_offset_y,
    input  logic signed [8:0]  i_plays_left,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [23:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import kta_pkg::*;

    typedef struct packed {
        logic [31:0] color_argb;
        logic [23:0] angle_deg;
        logic [15:0] scale_factor;
        logic [15:0] offset_x;
        logic [15:0] offset_y;
        logic [8:0]  plays_left;
    } t_frame;

    t_frame frame_q[$];

    // shadow of the animator state
    logic [23:0] cyc_len;
    int          plays;
    logic [31:0] elapsed;
    int          nkeys [NUM_TRACKS];
    logic [23:0] kstart [NUM_TRACKS][MAX_KEYS];
    logic [23:0] kspan  [NUM_TRACKS][MAX_KEYS];
    longint      kx     [NUM_TRACKS][MAX_KEYS];
    longint      ky     [NUM_TRACKS][MAX_KEYS];

    function automatic longint lerp(longint a, longint b, longint d, longint span);
        return (a * (span - d) + b * d) / span;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [23:0] rb_swap(longint c);
        logic [31:0] w;
        w = c[31:0];
        return {w[7:0], w[15:8], w[23:16]};
    endfunction

    function automatic int search(int t, logic [31:0] now);
        longint e;
        for (int i = 0; i < nkeys[t]; i++) begin
            e = longint'(kstart[t][i]) + longint'(kspan[t][i]);
            if (kstart[t][i] < now && now <= e) return i;
        end
        return -1;
    endfunction

    function automatic longint track_value(int t, logic [31:0] now, bit want_y);
        int n, k, j;
        n = nkeys[t];
        k = search(t, now);
        if (k < 0) return want_y ? ky[t][n-1] : kx[t][n-1];
        j = (k + 1 < n) ? k + 1 : 0;
        return lerp(want_y ? ky[t][k] : kx[t][k], want_y ? ky[t][j] : kx[t][j],
                    longint'(now) - longint'(kstart[t][k]), longint'(kspan[t][k]));
    endfunction

    function automatic logic [23:0] colour_value(logic [31:0] now, bit done);
        int n, k;
        logic [23:0] c1, c2, r;
        n = nkeys[TRK_COLOR];
        if (n == 0) return 24'hffffff;
        if (done) return rb_swap(kx[TRK_COLOR][n-1]);
        k = search(TRK_COLOR, now);
        if (k < 0) return rb_swap(kx[TRK_COLOR][n-1]);
        if (k + 1 >= n) return rb_swap(kx[TRK_COLOR][k]);
        c1 = rb_swap(kx[TRK_COLOR][k]);
        c2 = rb_swap(kx[TRK_COLOR][k+1]);
        for (int s = 0; s < 24; s += 8)
            r[s +: 8] = 8'(lerp(c1[s +: 8], c2[s +: 8],
                longint'(now) - longint'(kstart[TRK_COLOR][k]),
                longint'(kspan[TRK_COLOR][k])));
        return r;
    endfunction

    // advance the shadow by one item, queueing the expected frame for a tick
    task automatic animate(logic [1:0] kind, logic [2:0] trk, logic [23:0] st,
                           logic [23:0] sp, logic [31:0] vx, logic [15:0] vy,
                           logic [15:0] ms);
        longint sum, ang, scl, ox, oy;
        logic [31:0] cyc, now;
        logic [7:0]  alpha;
        bit done;
        int t;
        t_frame f;
        t = trk;
        if (kind == KIND_CLEAR) begin
            foreach (nkeys[i]) nkeys[i] = 0;
        end else if (kind == KIND_APPEND) begin
            if (t < NUM_TRACKS && nkeys[t] < MAX_KEYS) begin
                kstart[t][nkeys[t]] = st;
                kspan[t][nkeys[t]]  = sp;
                kx[t][nkeys[t]]     = longint'($signed(vx));
                ky[t][nkeys[t]]     = longint'($signed(vy));
                nkeys[t]++;
            end
        end else if (kind == KIND_TICK && plays != 0) begin
            sum = longint'(elapsed) + longint'(ms);
            elapsed = sum > 64'hffffffff ? 32'hffffffff : sum[31:0];
            cyc = cyc_len == 0 ? 32'd1 : 32'(cyc_len);
            if (elapsed > cyc && plays > 0) plays--;
            done = elapsed > cyc && plays != -1;
            now = elapsed % cyc;
            if (nkeys[TRK_ALPHA] == 0) alpha = 8'hff;
            else if (done) alpha = kx[TRK_ALPHA][nkeys[TRK_ALPHA]-1][7:0];
            else alpha = 8'(track_value(TRK_ALPHA, now, 0));
            ang = (nkeys[TRK_ANGLE] == 0 || done) ? 0 : track_value(TRK_ANGLE, now, 0);
            if (nkeys[TRK_SCALE] == 0) scl = 256;
            else if (done) scl = kx[TRK_SCALE][nkeys[TRK_SCALE]-1];
            else scl = track_value(TRK_SCALE, now, 0);
            ox = 0;
            oy = 0;
            if (nkeys[TRK_OFFSET] != 0 && !done) begin
                ox = track_value(TRK_OFFSET, now, 0);
                oy = track_value(TRK_OFFSET, now, 1);
            end
            f.color_argb   = {alpha, colour_value(now, done)};
            f.angle_deg    = 24'(clamp(ang, -8388608, 8388607));
            f.scale_factor = 16'(clamp(scl, 0, 65535));
            f.offset_x     = 16'(clamp(ox, -32768, 32767));
            f.offset_y     = 16'(clamp(oy, -32768, 32767));
            f.plays_left   = 9'(plays);
            frame_q.insert(frame_q.size(), f);
        end
    endtask

    task automatic report(string what, logic [31:0] exp_v, logic [31:0] got_v);
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, got_v);
        o_errors++;
    endtask

    initial o_errors = 0;
    assign o_pending = frame_q.size();

    always @(posedge i_clk) begin
        t_frame e;
        if (!i_rst_n) begin
            cyc_len = 24'd3000;
            plays   = -1;
            elapsed = 0;
            foreach (nkeys[i]) nkeys[i] = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_CYCLE) cyc_len = i_cfg_data;
                else plays = int'($signed(i_cfg_data[8:0]));
            end
            if (i_valid && !i_in_stall)
                animate(i_kind, i_track, i_key_start, i_key_span, i_key_value,
                        i_key_value_y, i_tick_ms);
            if (i_out_valid && !i_out_stall) begin
                if (frame_q.size() == 0) begin
                    $display("%0t: unexpected frame, expected none, got %h", $time,
                             i_color_argb);
                    o_errors++;
                end else begin
                    e = frame_q.pop_front();
                    if (i_color_argb !== e.color_argb)
                        report("color_argb", e.color_argb, i_color_argb);
                    if (i_angle_deg !== e.angle_deg)
                        report("angle_deg", 32'(e.angle_deg), 32'(i_angle_deg));
                    if (i_scale_factor !== e.scale_factor)
                        report("scale_factor", 32'(e.scale_factor), 32'(i_scale_factor));
                    if (i_offset_x !== e.offset_x)
                        report("offset_x", 32'(e.offset_x), 32'(i_offset_x));
                    if (i_offset_y !== e.offset_y)
                        report("offset_y", 32'(e.offset_y), 32'(i_offset_y));
                    if (i_plays_left !== e.plays_left)
                        report("plays_left", 32'(e.plays_left), 32'(i_plays_left));
                end
            end
        end
    end
endmodule

// File: bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import kta_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_kind = KIND_CLEAR;
    logic [2:0]         i_track = TRK_COLOR;
    logic [23:0]        i_key_start = '0;
    logic [23:0]        i_key_span = '0;
    logic signed [31:0] i_key_value = '0;
    logic signed [15:0] i_key_value_y = '0;
    logic [15:0]        i_tick_ms = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [31:0]        o_color_argb;
    logic signed [23:0] o_angle_deg;
    logic [15:0]        o_scale_factor;
    logic signed [15:0] o_offset_x;
    logic signed [15:0] o_offset_y;
    logic signed [8:0]  o_plays_left;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_idx = CFG_CYCLE;
    logic [23:0]        i_cfg_data = '0;
    int                 errors;
    int                 pending;
    bit                 hold_off = 0;   // long receiver hold-off requested

    always #2 i_clk = ~i_clk;

    keyframe_track_animator DUT (.*);

    kta_checker checker_inst (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_kind, .i_track,
        .i_key_start, .i_key_span, .i_key_value, .i_key_value_y, .i_tick_ms,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_color_argb(o_color_argb),
        .i_angle_deg(o_angle_deg), .i_scale_factor(o_scale_factor),
        .i_offset_x(o_offset_x), .i_offset_y(o_offset_y), .i_plays_left(o_plays_left),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_errors(errors), .o_pending(pending)
    );

    // receiver stall pattern: calm stretches, random stalls, and long holds on request
    initial begin
        int mode, len;
        forever begin
            if (hold_off) begin
                @(posedge i_clk) i_stall <= 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_off = 0;
            end
            mode = $urandom_range(0, 2);
            len = $urandom_range(1, 60);
            repeat (len) begin
                @(posedge i_clk);
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    default: i_stall <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    // present one item and hold it until taken
    task automatic offer(logic [1:0] kind, logic [2:0] trk, logic [23:0] st,
                         logic [23:0] sp, logic [31:0] vx, logic [15:0] vy,
                         logic [15:0] ms);
        i_valid <= 1'b1;
        i_kind <= kind;
        i_track <= trk;
        i_key_start <= st;
        i_key_span <= sp;
        i_key_value <= vx;
        i_key_value_y <= vy;
        i_tick_ms <= ms;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic pause_item(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // wait until every frame is back, then let a tick in flight finish
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (1200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [23:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // random append: short spans and starts against a small cycle mostly
    task automatic rand_append(logic [2:0] trk, int cyc);
        logic [23:0] st, sp;
        if ($urandom_range(0, 9) == 0) begin
            st = 24'($urandom());
            sp = 24'($urandom());
        end else begin
            st = 24'($urandom_range(0, cyc));
            sp = 24'($urandom_range(0, cyc / 2 + 1));
        end
        offer(KIND_APPEND, trk, st, sp, $urandom(), 16'($urandom()), 16'($urandom()));
    endtask

    initial begin
        int cyc, burst;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty tracks, then one or two keys per track with extreme values
        offer(KIND_TICK, 3'd0, '0, '0, '0, '0, 16'd0);
        offer(KIND_APPEND, TRK_COLOR, 24'd0, 24'd1000, 32'h00ff8000, 16'h0, '0);
        offer(KIND_APPEND, TRK_COLOR, 24'd1000, 24'd1000, 32'h000080ff, 16'h0, '0);
        offer(KIND_APPEND, TRK_ALPHA, 24'd0, 24'd2999, 32'h7fffffff, 16'h0, '0);
        offer(KIND_APPEND, TRK_ALPHA, 24'd0, 24'd0, 32'h80000000, 16'h0, '0);
        offer(KIND_APPEND, TRK_ANGLE, 24'd0, 24'hffffff, 32'h7fffffff, 16'h7fff, '0);
        offer(KIND_APPEND, TRK_ANGLE, 24'hffffff, 24'hffffff, 32'h80000000, 16'h8000, '0);
        offer(KIND_APPEND, TRK_SCALE, 24'd10, 24'd100, 32'hffff0000, 16'h0, '0);
        offer(KIND_APPEND, TRK_OFFSET, 24'd0, 24'd500, 32'h00012345, 16'h8000, '0);
        offer(KIND_APPEND, TRK_OFFSET, 24'd500, 24'd500, 32'hfffe0000, 16'h7fff, '0);
        offer(KIND_APPEND, 3'd7, '0, '0, '0, '0, '0);   // bad track, ignored
        offer(2'd3, 3'd0, '0, '0, '0, '0, 16'hffff);     // unknown kind
        offer(KIND_TICK, 3'd0, '0, '0, '0, '0, 16'd250);
        offer(KIND_TICK, 3'd0, '0, '0, '0, '0, 16'd800);
        offer(KIND_TICK, 3'd0, '0, '0, '0, '0, 16'hffff);
        for (int i = 0; i < 17; i++)           // fill colour past full
            offer(KIND_APPEND, TRK_COLOR, 24'(i * 50), 24'd60, $urandom(), '0, '0);
        offer(KIND_TICK, 3'd0, '0, '0, '0, '0, 16'd1);
        drain();

        // finite plays, stopped, zero cycle, max cycle
        write_reg(CFG_PLAY, 24'd2);
        write_reg(CFG_CYCLE, 24'd100);
        repeat (5) offer(KIND_TICK, 3'd0, '0, '0, '0, '0, 16'd70);
        drain();
        write_reg(CFG_PLAY, 24'h1fe);                    // negative, not looping
        write_reg(CFG_CYCLE, 24'd0);
        repeat (2) offer(KIND_TICK, 3'd0, '0, '0, '0, '0, 16'd3);
        drain();
        write_reg(CFG_PLAY, 24'd0);
        offer(KIND_TICK, 3'd0, '0, '0, '0, '0, 16'd3);
        drain();
        write_reg(CFG_PLAY, 24'd255);
        write_reg(CFG_CYCLE, 24'hffffff);
        offer(KIND_TICK, 3'd0, '0, '0, '0, '0, 16'hffff);
        drain();

        // random phases: new settings, a clear, a fill, then a run of mostly ticks with some appends and clears
        for (int ph = 0; ph < 40; ph++) begin
            case ($urandom_range(0, 3))
                0: cyc = $urandom_range(1, 20);
                1: cyc = $urandom_range(100, 3000);
                2: cyc = $urandom_range(1, 24'hffffff);
                default: cyc = $urandom_range(0, 1);
            endcase
            write_reg(CFG_CYCLE, 24'(cyc));
            case ($urandom_range(0, 3))
                0: write_reg(CFG_PLAY, 24'h1ff);
                1: write_reg(CFG_PLAY, 24'($urandom_range(1, 255)));
                2: write_reg(CFG_PLAY, 24'($urandom_range(256, 511)));
                default: write_reg(CFG_PLAY, 24'($urandom_range(0, 3)));
            endcase
            if (cyc == 0) cyc = 1;
            offer(KIND_CLEAR, 3'd0, '0, '0, '0, '0, '0);
            for (int t = 0; t < 5; t++)
                repeat ($urandom_range(0, ph % 8 == 0 ? 18 : 5))
                    rand_append(3'(t), cyc > 100000 ? 100000 : cyc);
            if (ph % 13 == 5) hold_off = 1;
            for (int n = 0; n < 25; n++) begin
                burst = $urandom_range(0, 2);
                if ($urandom_range(0, 9) == 0)
                    rand_append(3'($urandom_range(0, 7)), cyc > 100000 ? 100000 : cyc);
                else if ($urandom_range(0, 39) == 0)
                    offer(KIND_CLEAR, 3'd0, '0, '0, '0, '0, '0);
                else
                    offer(KIND_TICK, 3'($urandom()), 24'($urandom()), 24'($urandom()),
                          $urandom(), 16'($urandom()),
                          $urandom_range(0, 1) ? 16'($urandom_range(0, 2 * cyc))
                                               : 16'($urandom()));
                if (burst == 0) pause_item($urandom_range(1, 300));
            end
            drain();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule

// File: files.f
rtl/kta_pkg.sv
rtl/kta_ram.sv
rtl/kta_mod.sv
rtl/kta_blend.sv
rtl/keyframe_track_animator.sv
bench/kta_checker.sv
bench/testbench.sv
